// File: hw/rtl/sctu_pkg.sv
// Package for the supervisor CSR and trap unit.
// Holds payload structs, decode classes, status codes and CSR constants.
// No dependencies.
package sctu_pkg;

	localparam int unsigned XLEN = 64;

	// Status codes returned with each result
	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_NOT_SYS   = 3'd1;
	localparam logic [2:0] ST_BAD_PRIV  = 3'd2;
	localparam logic [2:0] ST_BAD_CSROP = 3'd3;
	localparam logic [2:0] ST_NO_CSR    = 3'd4;

	// Item classes handed from the decoder to the executor
	localparam logic [2:0] KIND_ERR    = 3'd0;
	localparam logic [2:0] KIND_TRAP   = 3'd1;
	localparam logic [2:0] KIND_SFENCE = 3'd2;
	localparam logic [2:0] KIND_WFI    = 3'd3;
	localparam logic [2:0] KIND_SRET   = 3'd4;
	localparam logic [2:0] KIND_CSR    = 3'd5;

	// CSR operations (funct3 low bits)
	localparam logic [1:0] OP_SWAP    = 2'd1;
	localparam logic [1:0] OP_SETBITS = 2'd2;
	localparam logic [1:0] OP_CLRBITS = 2'd3;

	localparam logic [6:0]  SYS_OPCODE    = 7'h73;
	localparam logic [6:0]  F7_SFENCE     = 7'h09;
	localparam logic [6:0]  F7_PRIV       = 7'h08;
	localparam logic [4:0]  RS2_WFI       = 5'd5;
	localparam logic [4:0]  RS2_SUP_RET   = 5'd2;

	localparam logic [11:0] CSRN_SSTATUS  = 12'h100;
	localparam logic [11:0] CSRN_SIE      = 12'h104;
	localparam logic [11:0] CSRN_STVEC    = 12'h105;
	localparam logic [11:0] CSRN_SSCRATCH = 12'h140;
	localparam logic [11:0] CSRN_SEPC     = 12'h141;
	localparam logic [11:0] CSRN_SCAUSE   = 12'h142;
	localparam logic [11:0] CSRN_STVAL    = 12'h143;
	localparam logic [11:0] CSRN_SIP      = 12'h144;
	localparam logic [11:0] CSRN_SATP     = 12'h180;

	localparam int unsigned SIE_BIT  = 1;
	localparam int unsigned SPIE_BIT = 5;
	localparam int unsigned SPP_BIT  = 8;

	localparam logic [63:0] STATUS_RESET    = 64'h8000_0000_0001_E000;
	localparam logic [63:0] SATP_ASID_MASK  = 64'h0FFF_F000_0000_0000;
	localparam logic [63:0] STATUS_MASK_RST = 64'h0000_0000_000C_0122;
	localparam logic [63:0] INTR_MASK_RST   = 64'h0000_0000_0000_0222;
	localparam logic [3:0]  ATP_MODE_OFF     = 4'd0;
	localparam logic [3:0]  ATP_MODE_PAGED39 = 4'd8;

	// Configuration register indexes
	localparam logic CFG_STATUS_MASK = 1'b0;
	localparam logic CFG_INTR_MASK   = 1'b1;

	typedef enum logic [3:0] {
		SEL_SSTATUS,
		SEL_SIE,
		SEL_STVEC,
		SEL_SSCRATCH,
		SEL_SEPC,
		SEL_SCAUSE,
		SEL_STVAL,
		SEL_SIP,
		SEL_SATP
	} csr_sel_t;

	typedef struct packed {
		logic        command;
		logic [31:0] instruction;
		logic [63:0] source_value;
		logic [63:0] current_pc;
		logic [63:0] trap_cause;
		logic [63:0] trap_value;
	} in_item_t;

	typedef struct packed {
		logic [63:0] next_pc;
		logic        rd_write;
		logic [4:0]  rd_index;
		logic [63:0] rd_value;
		logic        flush_vm;
		logic        user_mode;
		logic [2:0]  status;
	} out_item_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic [2:0]  status;
		csr_sel_t    csr;
		logic [1:0]  op;
		logic        wr;
		logic [4:0]  rd;
		logic [63:0] wval;
		logic [63:0] pc;
		logic [63:0] pc4;
		logic [63:0] cause;
		logic [63:0] tval;
	} dec_item_t;

endpackage

// File: hw/rtl/sctu_decode.sv
// Front end of the CSR unit: classifies one incoming item.
// Depends on sctu_pkg.
module sctu_decode (
	input  sctu_pkg::in_item_t  item,
	output sctu_pkg::dec_item_t dec
);
	import sctu_pkg::*;

	logic [6:0]  opc;
	logic [4:0]  rd;
	logic [2:0]  f3;
	logic [4:0]  rs1;
	logic [4:0]  rs2;
	logic [6:0]  f7;
	logic [11:0] num;
	logic        csr_ok;
	csr_sel_t    sel;

	assign opc = item.instruction[6:0];
	assign rd  = item.instruction[11:7];
	assign f3  = item.instruction[14:12];
	assign rs1 = item.instruction[19:15];
	assign rs2 = item.instruction[24:20];
	assign f7  = item.instruction[31:25];
	assign num = item.instruction[31:20];

	always_comb begin
		csr_ok = 1'b1;
		sel    = SEL_SSTATUS;
		unique case (num)
			CSRN_SSTATUS:  sel = SEL_SSTATUS;
			CSRN_SIE:      sel = SEL_SIE;
			CSRN_STVEC:    sel = SEL_STVEC;
			CSRN_SSCRATCH: sel = SEL_SSCRATCH;
			CSRN_SEPC:     sel = SEL_SEPC;
			CSRN_SCAUSE:   sel = SEL_SCAUSE;
			CSRN_STVAL:    sel = SEL_STVAL;
			CSRN_SIP:      sel = SEL_SIP;
			CSRN_SATP:     sel = SEL_SATP;
			default:       csr_ok = 1'b0;
		endcase
	end

	always_comb begin
		dec.kind   = KIND_ERR;
		dec.status = ST_OK;
		dec.csr    = sel;
		dec.op     = f3[1:0];
		dec.wr     = (rs1 != 5'd0);
		dec.rd     = rd;
		dec.wval   = f3[2] ? {59'd0, rs1} : ((rs1 == 5'd0) ? 64'd0 : item.source_value);
		dec.pc     = item.current_pc;
		dec.pc4    = item.current_pc + 64'd4;
		dec.cause  = item.trap_cause;
		dec.tval   = item.trap_value;
		priority if (item.command) begin
			dec.kind = KIND_TRAP;
		end else if (opc != SYS_OPCODE) begin
			dec.status = ST_NOT_SYS;
		end else if (f3 == 3'd0) begin
			priority if (f7 == F7_SFENCE && rd == 5'd0) begin
				dec.kind = KIND_SFENCE;
			end else if (f7 == F7_PRIV && rs2 == RS2_WFI && rs1 == 5'd0 && rd == 5'd0) begin
				dec.kind = KIND_WFI;
			end else if (f7 == F7_PRIV && rs2 == RS2_SUP_RET && rs1 == 5'd0
					&& rd == 5'd0) begin
				dec.kind = KIND_SRET;
			end else begin
				dec.status = ST_BAD_PRIV;
			end
		end else if (f3[1:0] == 2'd0) begin
			dec.status = ST_BAD_CSROP;
		end else if (!csr_ok) begin
			dec.status = ST_NO_CSR;
		end else begin
			dec.kind = KIND_CSR;
		end
	end

endmodule

// File: hw/rtl/sctu_queue.sv
// Two-entry queue between the decoder and the executor.
// Depends on nothing; width set by parameter.
module sctu_queue #(
	parameter int unsigned WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic             nonempty,
	output logic [WIDTH-1:0] pop_data
);

	logic [WIDTH-1:0] mem_q [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       count_q;

	assign full     = (count_q == 2'd2);
	assign nonempty = (count_q != 2'd0);
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
		end
	end

`ifndef SYNTH
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != 2'd3)
		else $error("queue count out of range");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> nonempty)
		else $error("queue popped while empty");
`endif

endmodule

// File: hw/rtl/sctu_exec.sv
// Back end of the CSR unit: CSR state, privilege, trap entry and result register.
// Depends on sctu_pkg.
module sctu_exec (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_write_en,
	input  logic                cfg_index,
	input  logic [63:0]         cfg_wdata,
	input  logic                item_valid,
	input  sctu_pkg::dec_item_t item,
	output logic                item_pop,
	output logic                out_valid,
	input  logic                out_ready,
	output sctu_pkg::out_item_t out_data
);
	import sctu_pkg::*;

	logic [63:0] smask_q, imask_q;
	logic        user_q;
	logic [63:0] sscratch_q, stvec_q, sepc_q, scause_q, stval_q;
	logic [63:0] sstatus_q, sie_q, sip_q, satp_q;

	logic        user_d;
	logic [63:0] sscratch_d, stvec_d, sepc_d, scause_d, stval_d;
	logic [63:0] sstatus_d, sie_d, sip_d, satp_d;

	logic [63:0] old, newv, base;
	logic        do_write;
	logic        out_valid_q;
	out_item_t   out_q, res;

	assign item_pop  = item_valid && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign base      = {stvec_q[63:2], 2'b00};

	always_comb begin
		unique case (item.csr)
			SEL_SSTATUS:  old = sstatus_q;
			SEL_SIE:      old = sie_q;
			SEL_STVEC:    old = stvec_q;
			SEL_SSCRATCH: old = sscratch_q;
			SEL_SEPC:     old = sepc_q;
			SEL_SCAUSE:   old = scause_q;
			SEL_STVAL:    old = stval_q;
			SEL_SIP:      old = sip_q;
			SEL_SATP:     old = satp_q;
			default:      old = 64'd0;
		endcase
		unique case (item.op)
			OP_SETBITS: newv = old | item.wval;
			OP_CLRBITS: newv = old & ~item.wval;
			default:    newv = item.wval;
		endcase
		do_write = (item.op == OP_SWAP) || item.wr;
	end

	always_comb begin
		user_d     = user_q;
		sscratch_d = sscratch_q;
		stvec_d    = stvec_q;
		sepc_d     = sepc_q;
		scause_d   = scause_q;
		stval_d    = stval_q;
		sstatus_d  = sstatus_q;
		sie_d      = sie_q;
		sip_d      = sip_q;
		satp_d     = satp_q;
		res.next_pc  = item.pc;
		res.rd_write = 1'b0;
		res.rd_index = 5'd0;
		res.rd_value = 64'd0;
		res.flush_vm = 1'b0;
		res.status   = item.status;
		unique case (item.kind)
			KIND_TRAP: begin
				sepc_d   = item.pc;
				scause_d = item.cause;
				stval_d  = item.tval;
				sstatus_d[SPP_BIT]  = ~user_q;
				sstatus_d[SPIE_BIT] = sstatus_q[SIE_BIT];
				sstatus_d[SIE_BIT]  = 1'b0;
				user_d = 1'b0;
				if (stvec_q[1:0] == 2'b01 && item.cause[63]) begin
					res.next_pc = base + {item.cause[61:0], 2'b00};
				end else begin
					res.next_pc = base;
				end
				res.flush_vm = 1'b1;
			end
			KIND_SFENCE: begin
				res.flush_vm = 1'b1;
				res.next_pc  = item.pc4;
			end
			KIND_WFI: begin
				res.next_pc = item.pc4;
			end
			KIND_SRET: begin
				sstatus_d[SIE_BIT]  = sstatus_q[SPIE_BIT];
				sstatus_d[SPIE_BIT] = 1'b1;
				sstatus_d[SPP_BIT]  = 1'b0;
				user_d       = ~sstatus_q[SPP_BIT];
				res.flush_vm = ~sstatus_q[SPP_BIT];
				res.next_pc  = sepc_q;
			end
			KIND_CSR: begin
				if (do_write) begin
					unique case (item.csr)
						SEL_SSTATUS:  sstatus_d = (newv & smask_q) | (sstatus_q & ~smask_q);
						SEL_SIE:      sie_d = (newv & imask_q) | (sie_q & ~imask_q);
						SEL_SIP:      sip_d = (newv & imask_q) | (sip_q & ~imask_q);
						SEL_STVEC:    stvec_d = newv[1] ? {newv[63:2], 2'b00} : newv;
						SEL_SSCRATCH: sscratch_d = newv;
						SEL_SEPC:     sepc_d = newv;
						SEL_SCAUSE:   scause_d = newv;
						SEL_STVAL:    stval_d = newv;
						SEL_SATP: begin
							if (newv[63:60] == ATP_MODE_OFF ||
								newv[63:60] == ATP_MODE_PAGED39) begin
								satp_d       = newv & ~SATP_ASID_MASK;
								res.flush_vm = 1'b1;
							end
						end
						default: ;
					endcase
				end
				res.rd_index = item.rd;
				res.rd_write = (item.rd != 5'd0);
				res.rd_value = (item.rd != 5'd0) ? old : 64'd0;
				res.next_pc  = item.pc4;
			end
			default: ;
		endcase
		res.user_mode = user_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			smask_q     <= STATUS_MASK_RST;
			imask_q     <= INTR_MASK_RST;
			user_q      <= 1'b0;
			sscratch_q  <= 64'd0;
			stvec_q     <= 64'd0;
			sepc_q      <= 64'd0;
			scause_q    <= 64'd0;
			stval_q     <= 64'd0;
			sstatus_q   <= STATUS_RESET;
			sie_q       <= 64'd0;
			sip_q       <= 64'd0;
			satp_q      <= 64'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_write_en) begin
				unique case (cfg_index)
					CFG_STATUS_MASK: smask_q <= cfg_wdata;
					CFG_INTR_MASK:   imask_q <= cfg_wdata;
					default: ;
				endcase
			end
			if (item_pop) begin
				user_q     <= user_d;
				sscratch_q <= sscratch_d;
				stvec_q    <= stvec_d;
				sepc_q     <= sepc_d;
				scause_q   <= scause_d;
				stval_q    <= stval_d;
				sstatus_q  <= sstatus_d;
				sie_q      <= sie_d;
				sip_q      <= sip_d;
				satp_q     <= satp_d;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item_pop) begin
			out_q <= res;
		end
	end

`ifndef SYNTH
	a_trap_to_super: assert property (@(posedge clk) disable iff (!arst_n)
		item_pop && item.kind == KIND_TRAP |=> !user_q && out_q.flush_vm)
		else $error("trap entry did not land in supervisor mode");
	a_satp_mode: assert property (@(posedge clk) disable iff (!arst_n)
		satp_q[63:60] == ATP_MODE_OFF || satp_q[63:60] == ATP_MODE_PAGED39)
		else $error("satp holds an unsupported mode");
	a_stvec_warl: assert property (@(posedge clk) disable iff (!arst_n)
		!stvec_q[1])
		else $error("stvec holds a reserved mode");
`endif

endmodule

// File: hw/rtl/supervisor_csr_and_trap_unit.sv
// Top level of the supervisor CSR and trap unit.
// Depends on sctu_pkg, sctu_decode, sctu_queue and sctu_exec.
//
// Usage:
//   Input channel (in_valid/in_ready/in_data) carries one transaction per
//   SYSTEM instruction or trap entry. Output channel (out_valid/out_ready/
//   out_data) returns exactly one result transaction for each input, in order.
//   cfg_write_en/cfg_index/cfg_wdata write the sstatus and sie/sip write
//   masks; write them only while the unit is idle.
//   An accepted transaction is held in the decode queue, and then its result
//   is captured in the result register, which drives out_data.
//   Throughput: one transaction per cycle while out_ready stays high, limited
//   by the CSR read-modify-write in the executor.
//   When the receiver stalls, the result register holds its transaction and
//   the two-entry queue absorbs up to two more before in_ready drops.
//   Reset: all CSRs take their architectural reset values (sstatus with
//   FS, XS and SD set, the rest zero), privilege is supervisor, both write
//   masks return to their defaults and the queue empties.
module supervisor_csr_and_trap_unit (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_write_en,
	input  logic                 cfg_index,
	input  logic [63:0]          cfg_wdata,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  sctu_pkg::in_item_t   in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output sctu_pkg::out_item_t  out_data
);
	import sctu_pkg::*;

	dec_item_t dec;
	dec_item_t head;
	logic      q_full;
	logic      q_nonempty;
	logic      q_pop;

	// Classify the incoming transaction
	sctu_decode u_decode (
		.item (in_data),
		.dec  (dec)
	);

	// Accept whenever the queue has room
	assign in_ready = !q_full;

	sctu_queue #(
		.WIDTH ($bits(dec_item_t))
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (in_valid && in_ready),
		.push_data (dec),
		.full      (q_full),
		.pop       (q_pop),
		.nonempty  (q_nonempty),
		.pop_data  (head)
	);

	// Execute the head transaction and hold its result until taken
	sctu_exec u_exec (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write_en (cfg_write_en),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata),
		.item_valid   (q_nonempty),
		.item         (head),
		.item_pop     (q_pop),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.out_data     (out_data)
	);

endmodule

// File: bench/tb.sv
// Self-checking bench for supervisor_csr_and_trap_unit: random and directed
// SYSTEM instructions and trap entries, each result checked against a predictor.
// Depends on sctu_pkg and the unit's RTL.
`timescale 1ns / 100ps

module tb;
	import sctu_pkg::*;

	// Predictor of the CSR file plus the queue of results it has worked out
	class csr_scoreboard;
		logic [63:0] status_mask, intr_mask;
		logic        in_user;
		logic [63:0] sscratch, stvec, sepc, scause, stval, sstatus, sie, sip, satp;
		out_item_t   pending_results[$];
		int          mismatches;

		function void reset_state();
			status_mask = STATUS_MASK_RST;
			intr_mask = INTR_MASK_RST;
			in_user = 1'b0;
			sscratch = '0; stvec = '0; sepc = '0; scause = '0; stval = '0;
			sstatus = STATUS_RESET; sie = '0; sip = '0; satp = '0;
			pending_results.delete();
			mismatches = 0;
		endfunction

		function void write_mask(logic idx, logic [63:0] v);
			if (idx == CFG_STATUS_MASK)
				status_mask = v;
			else
				intr_mask = v;
		endfunction

		function bit csr_lookup(logic [11:0] num, output logic [63:0] v);
			v = '0;
			case (num)
				CSRN_SSTATUS:  v = sstatus;
				CSRN_SIE:      v = sie;
				CSRN_STVEC:    v = stvec;
				CSRN_SSCRATCH: v = sscratch;
				CSRN_SEPC:     v = sepc;
				CSRN_SCAUSE:   v = scause;
				CSRN_STVAL:    v = stval;
				CSRN_SIP:      v = sip;
				CSRN_SATP:     v = satp;
				default:       return 1'b0;
			endcase
			return 1'b1;
		endfunction

		// Returns 1 when the write asks for a translation flush
		function bit csr_update(logic [11:0] num, logic [63:0] v);
			case (num)
				CSRN_SSCRATCH: sscratch = v;
				CSRN_STVEC:    stvec = (v[1:0] <= 2'd1) ? v : {v[63:2], 2'b00};
				CSRN_SEPC:     sepc = v;
				CSRN_SSTATUS:  sstatus = (v & status_mask) | (sstatus & ~status_mask);
				CSRN_SIE:      sie = (v & intr_mask) | (sie & ~intr_mask);
				CSRN_SIP:      sip = (v & intr_mask) | (sip & ~intr_mask);
				CSRN_SCAUSE:   scause = v;
				CSRN_STVAL:    stval = v;
				CSRN_SATP:
					if (v[63:60] == ATP_MODE_OFF || v[63:60] == ATP_MODE_PAGED39) begin
						satp = v & ~SATP_ASID_MASK;
						return 1'b1;
					end
				default: ;
			endcase
			return 1'b0;
		endfunction

		// Note an accepted transaction and queue the result it must cause
		function void note_input(in_item_t it);
			out_item_t   r;
			logic [31:0] ins;
			logic [63:0] old, wv;
			logic [1:0]  op;
			bit          wr;
			ins = it.instruction;
			r = '0;
			r.next_pc = it.current_pc;
			if (it.command) begin
				sepc = it.current_pc;
				scause = it.trap_cause;
				stval = it.trap_value;
				sstatus[SPP_BIT] = !in_user;
				in_user = 1'b0;
				sstatus[SPIE_BIT] = sstatus[SIE_BIT];
				sstatus[SIE_BIT] = 1'b0;
				if (stvec[1:0] == 2'd1 && it.trap_cause[63])
					r.next_pc = {stvec[63:2], 2'b00} + (it.trap_cause << 2);
				else
					r.next_pc = {stvec[63:2], 2'b00};
				r.flush_vm = 1'b1;
			end else if (ins[6:0] != SYS_OPCODE) begin
				r.status = ST_NOT_SYS;
			end else if (ins[14:12] == 3'd0) begin
				if (ins[31:25] == F7_SFENCE && ins[11:7] == 5'd0) begin
					r.flush_vm = 1'b1;
					r.next_pc = it.current_pc + 64'd4;
				end else if (ins[31:25] == F7_PRIV && ins[24:20] == RS2_WFI
						&& ins[19:15] == 5'd0 && ins[11:7] == 5'd0) begin
					r.next_pc = it.current_pc + 64'd4;
				end else if (ins[31:25] == F7_PRIV && ins[24:20] == RS2_SUP_RET
						&& ins[19:15] == 5'd0 && ins[11:7] == 5'd0) begin
					in_user = !sstatus[SPP_BIT];
					sstatus[SIE_BIT] = sstatus[SPIE_BIT];
					sstatus[SPIE_BIT] = 1'b1;
					sstatus[SPP_BIT] = 1'b0;
					r.flush_vm = in_user;
					r.next_pc = sepc;
				end else begin
					r.status = ST_BAD_PRIV;
				end
			end else begin
				op = ins[13:12];
				if (ins[14])
					wv = {59'd0, ins[19:15]};
				else
					wv = (ins[19:15] == 5'd0) ? 64'd0 : it.source_value;
				wr = ins[14] ? (wv != 0) : (ins[19:15] != 5'd0);
				if (op == 2'd0) begin
					r.status = ST_BAD_CSROP;
				end else if (!csr_lookup(ins[31:20], old)) begin
					r.status = ST_NO_CSR;
				end else begin
					if (op == OP_SWAP)
						r.flush_vm = csr_update(ins[31:20], wv);
					else if (wr)
						r.flush_vm = csr_update(ins[31:20],
							op == OP_SETBITS ? (old | wv) : (old & ~wv));
					r.rd_index = ins[11:7];
					if (ins[11:7] != 5'd0) begin
						r.rd_write = 1'b1;
						r.rd_value = old;
					end
					r.next_pc = it.current_pc + 64'd4;
				end
			end
			r.user_mode = in_user;
			pending_results.push_back(r);
		endfunction

		// Compare one accepted result with the oldest expectation
		function void check_result(out_item_t got);
			out_item_t e;
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result %h", got);
				return;
			end
			e = pending_results.pop_front();
			if (got.next_pc !== e.next_pc || got.rd_write !== e.rd_write
					|| got.rd_index !== e.rd_index || got.rd_value !== e.rd_value
					|| got.flush_vm !== e.flush_vm || got.user_mode !== e.user_mode
					|| got.status !== e.status) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("mismatch: exp pc=%h rdw=%b rd=%0d rdv=%h fl=%b u=%b st=%0d",
						e.next_pc, e.rd_write, e.rd_index, e.rd_value, e.flush_vm,
						e.user_mode, e.status);
					$display("          got pc=%h rdw=%b rd=%0d rdv=%h fl=%b u=%b st=%0d",
						got.next_pc, got.rd_write, got.rd_index, got.rd_value,
						got.flush_vm, got.user_mode, got.status);
				end
			end
		endfunction
	endclass

	localparam int STALL_LIMIT = 2000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_write_en = 1'b0;
	logic        cfg_index = 1'b0;
	logic [63:0] cfg_wdata = '0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	in_item_t    in_data = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	out_item_t   out_data;

	csr_scoreboard sb;
	int          idle_cycles = 0;
	bit          hang = 1'b0;
	bit          sending_done = 1'b0;

	supervisor_csr_and_trap_unit dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_write_en(cfg_write_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Watchdog: count cycles with no transaction on either channel
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT)
			hang <= 1'b1;
	end

	// Receiver: random stalls, sometimes long stretches always ready
	initial begin : receiver
		int gap;
		int burst;
		burst = 0;
		@(posedge arst_n);
		forever begin
			if (burst > 0) begin
				burst--;
				gap = 0;
			end else begin
				gap = $urandom_range(0, 7);
				if ($urandom_range(0, 31) == 0)
					burst = $urandom_range(20, 80);
			end
			if (gap > 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
			sb.check_result(out_data);
		end
	end

	// Build one input transaction; most are well-formed SYSTEM instructions
	function automatic in_item_t random_item();
		in_item_t    it;
		logic [11:0] csrs [9];
		logic [11:0] num;
		logic [2:0]  f3;
		int          pick;
		csrs = '{CSRN_SSTATUS, CSRN_SIE, CSRN_STVEC, CSRN_SSCRATCH, CSRN_SEPC,
			CSRN_SCAUSE, CSRN_STVAL, CSRN_SIP, CSRN_SATP};
		it.command = 1'b0;
		it.source_value = {$urandom, $urandom};
		it.current_pc = {$urandom, $urandom};
		it.trap_cause = {$urandom, $urandom};
		it.trap_value = {$urandom, $urandom};
		it.instruction = $urandom;
		pick = $urandom_range(0, 99);
		if (pick < 60) begin
			num = ($urandom_range(0, 15) == 0) ? 12'($urandom) : csrs[$urandom_range(0, 8)];
			f3 = ($urandom_range(0, 15) == 0) ? 3'd4 : 3'($urandom_range(1, 7));
			if (f3 == 3'd4 && $urandom_range(0, 1)) f3 = 3'($urandom_range(5, 7));
			it.instruction = {num, 5'($urandom), f3, 5'($urandom), SYS_OPCODE};
			if ($urandom_range(0, 3) == 0)
				it.instruction[19:15] = 5'd0;
			// steer satp writes toward legal modes now and then
			if ($urandom_range(0, 1))
				it.source_value[63:60] = $urandom_range(0, 1) ? ATP_MODE_PAGED39
					: ATP_MODE_OFF;
		end else if (pick < 75) begin
			it.command = 1'b1;
			if ($urandom_range(0, 1)) it.trap_cause[62:4] = '0;
		end else if (pick < 88) begin
			case ($urandom_range(0, 2))
				0: it.instruction = {F7_SFENCE, 5'($urandom), 5'($urandom), 3'd0,
					5'd0, SYS_OPCODE};
				1: it.instruction = {F7_PRIV, RS2_WFI, 5'd0, 3'd0, 5'd0, SYS_OPCODE};
				default: it.instruction = {F7_PRIV, RS2_SUP_RET, 5'd0, 3'd0, 5'd0,
					SYS_OPCODE};
			endcase
		end else if (pick < 94) begin
			it.instruction[14:0] = {3'd0, 5'($urandom), SYS_OPCODE};
		end
		return it;
	endfunction

	// Drive one transaction and hold it until accepted
	task automatic send_item(in_item_t it, int gap);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= it;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sb.note_input(it);
	endtask

	task automatic csr_item(logic [11:0] num, logic [2:0] f3, logic [4:0] rs1,
			logic [4:0] rd, logic [63:0] src);
		in_item_t it;
		it = '0;
		it.instruction = {num, rs1, f3, rd, SYS_OPCODE};
		it.source_value = src;
		it.current_pc = {$urandom, $urandom};
		send_item(it, 0);
	endtask

	task automatic trap_item(logic [63:0] cause, logic [63:0] tval);
		in_item_t it;
		it = '0;
		it.command = 1'b1;
		it.current_pc = {$urandom, $urandom};
		it.trap_cause = cause;
		it.trap_value = tval;
		send_item(it, 0);
	endtask

	// Drain every expected result and let the pipeline settle before masks are written
	task automatic quiesce();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending_results.size() != 0 && !hang) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_masks(logic [63:0] smask, logic [63:0] imask);
		cfg_write_en <= 1'b1;
		cfg_index <= CFG_STATUS_MASK;
		cfg_wdata <= smask;
		@(posedge clk);
		sb.write_mask(CFG_STATUS_MASK, smask);
		cfg_index <= CFG_INTR_MASK;
		cfg_wdata <= imask;
		@(posedge clk);
		sb.write_mask(CFG_INTR_MASK, imask);
		cfg_write_en <= 1'b0;
	endtask

	initial begin : stimulus
		in_item_t it;
		logic [63:0] smasks [4];
		logic [63:0] imasks [4];
		smasks = '{64'd0, '1, STATUS_MASK_RST, 64'hDEAD_BEEF_0123_4567};
		imasks = '{'1, 64'd0, 64'h0000_0000_0000_0AAA, INTR_MASK_RST};
		sb = new();
		sb.reset_state();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: every CSR, every op, both write forms, special cases
		csr_item(CSRN_STVEC, 3'd1, 5'd1, 5'd3, 64'h8000_0000_0000_1003);
		csr_item(CSRN_STVEC, 3'd1, 5'd1, 5'd4, 64'h0000_0000_0000_2001);
		trap_item(64'h8000_0000_0000_0005, '1);
		trap_item(64'h0000_0000_0000_0002, 64'd0);
		csr_item(CSRN_SATP, 3'd1, 5'd2, 5'd5, 64'h8FFF_FFFF_FFFF_FFFF);
		csr_item(CSRN_SATP, 3'd1, 5'd2, 5'd6, 64'h5000_0000_0000_0001);
		csr_item(CSRN_SSTATUS, 3'd2, 5'd1, 5'd7, '1);
		csr_item(CSRN_SSTATUS, 3'd3, 5'd1, 5'd31, 64'h100);
		csr_item(CSRN_SIE, 3'd6, 5'd31, 5'd1, 64'd0);
		csr_item(CSRN_SIP, 3'd7, 5'd31, 5'd2, 64'd0);
		csr_item(CSRN_SSCRATCH, 3'd5, 5'd31, 5'd0, 64'd0);
		csr_item(CSRN_SEPC, 3'd2, 5'd0, 5'd8, '1);
		csr_item(CSRN_SCAUSE, 3'd6, 5'd0, 5'd9, 64'd0);
		csr_item(CSRN_STVAL, 3'd3, 5'd0, 5'd10, 64'd0);
		csr_item(CSRN_SSCRATCH, 3'd4, 5'd1, 5'd11, '1);
		csr_item(12'hFFF, 3'd1, 5'd1, 5'd12, '1);
		it = '0;
		it.instruction = {F7_PRIV, RS2_SUP_RET, 5'd0, 3'd0, 5'd0, SYS_OPCODE};
		send_item(it, 0);
		it.instruction = {F7_PRIV, RS2_WFI, 5'd0, 3'd0, 5'd0, SYS_OPCODE};
		send_item(it, 0);
		it.instruction = {F7_SFENCE, 5'd3, 5'd4, 3'd0, 5'd0, SYS_OPCODE};
		send_item(it, 0);
		it.instruction = {F7_PRIV, RS2_SUP_RET, 5'd1, 3'd0, 5'd0, SYS_OPCODE};
		send_item(it, 0);
		it.instruction = '1;
		send_item(it, 0);
		it = '1;
		it.command = 1'b0;
		send_item(it, 0);

		// Random phases, one mask setting per phase, extremes included
		for (int phase = 0; phase < 4; phase++) begin
			quiesce();
			write_masks(smasks[phase], imasks[phase]);
			for (int n = 0; n < 425; n++) begin
				if (n == 200) begin
					// hold off until every expected result is back
					in_valid <= 1'b0;
					@(posedge clk);
					while (sb.pending_results.size() != 0 && !hang) @(posedge clk);
				end
				send_item(random_item(), ($urandom_range(0, 3) == 0) ? 0 :
					$urandom_range(0, 7));
				if (hang) break;
			end
		end
		in_valid <= 1'b0;
		sending_done = 1'b1;
	end

	initial begin : finisher
		wait (sending_done || hang);
		while (!hang && sb.pending_results.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (hang) begin
			$display("tb: FAIL");
		end else if (sb.mismatches == 0) begin
			$display("tb: PASS");
		end else begin
			$display("tb: FAIL");
		end
		$finish;
	end

endmodule
